// ===== rtl/bsa_pkg.sv =====
// Package: shared types and constants of the boid steering accumulator.
package bsa_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned RadW   = 23;
  localparam int unsigned AwayW  = 36;
  localparam int unsigned SumW   = 34;

  typedef enum logic [1:0] {
    REG_SEP = 2'd0,
    REG_COH = 2'd1,
    REG_ALI = 2'd2
  } reg_idx_t;

  // iterative unit operation codes
  typedef enum logic [1:0] {
    OP_SQRT = 2'd0,
    OP_DIV  = 2'd1
  } op_t;

  typedef struct packed {
    logic     start;
    op_t      op;
  } iu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iu_sts_t;

endpackage

// ===== rtl/bsa_iter_unit.sv =====
// Iterative unit: bit-serial square root and unsigned restoring division.
module bsa_iter_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bsa_pkg::iu_ctl_t       ctl,
  input  logic [63:0]            opa,
  input  logic [63:0]            opb,
  output bsa_pkg::iu_sts_t       sts,
  output logic [63:0]            res
);

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] den_r, den_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  bsa_pkg::op_t op_r, op_nxt;
  logic [64:0] trial;
  logic [64:0] shrem;

  always_comb begin
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    den_nxt  = den_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    op_nxt   = op_r;
    done_nxt = 1'b0;
    trial    = '0;
    shrem    = '0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      rem_nxt  = (ctl.op == bsa_pkg::OP_SQRT) ? opa : 64'd0;
      acc_nxt  = (ctl.op == bsa_pkg::OP_SQRT) ? 64'd0 : opa;
      den_nxt  = opb;
      bit_nxt  = 64'h4000_0000_0000_0000;
      cnt_nxt  = (ctl.op == bsa_pkg::OP_SQRT) ? 7'd32 : 7'd64;
    end else if (busy_r) begin
      if (op_r == bsa_pkg::OP_SQRT) begin
        trial = {1'b0, acc_r} + {1'b0, bit_r};
        if ({1'b0, rem_r} >= trial) begin
          rem_nxt = rem_r - trial[63:0];
          acc_nxt = (acc_r >> 1) + bit_r;
        end else begin
          acc_nxt = acc_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end else begin
        shrem = {rem_r, acc_r[63]};
        if (shrem >= {1'b0, den_r}) begin
          rem_nxt = shrem[63:0] - den_r;
          acc_nxt = {acc_r[62:0], 1'b1};
        end else begin
          rem_nxt = shrem[63:0];
          acc_nxt = {acc_r[62:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    den_r <= den_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
    op_r  <= op_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res      = acc_r;

endmodule

// ===== rtl/boid_steering_accumulator.sv =====
// Top level: boid steering accumulator (separation, cohesion, alignment).
// Usage:
//   in_*  channel: one neighbor item per handshake; tdata packs focal and
//         neighbor position/velocity, tuser is neighbor_is_self, tlast
//         marks the last neighbor and triggers one result.
//   out_* channel: one result item per list, six 24-bit steering fields.
//   cfg_* port: write-only radii, index 0 separation, 1 cohesion,
//         2 alignment; write only while idle.
// Items: one at a time. A self item passes only the radius test, an item
//   outside the separation radius also the accumulate step; inside it a
//   square root and two divisions come first, all on the shared iterative unit.
// Last item: each unit vector takes a square root and two divisions, the
//   cohesion and alignment means two divisions each, after the item's own work.
// The result sits in an output register. Items are still accepted while it
//   waits; the next last item holds before its result until the receiver
//   takes the previous one.
// Reset: synchronous, clears accumulators and loads the radius defaults.
module boid_steering_accumulator #(
  parameter int unsigned MAX_NEIGHBORS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // focal_pos_x, focal_pos_y, focal_vel_x, focal_vel_y,
  // neighbor_pos_x, neighbor_pos_y, neighbor_vel_x, neighbor_vel_y
  input  logic [191:0] in_tdata,
  input  logic         in_tuser,   // neighbor_is_self
  input  logic         in_tlast,   // last_neighbor
  output logic         out_tvalid,
  input  logic         out_tready,
  // separation_x, separation_y, cohesion_x, cohesion_y, alignment_x, alignment_y
  output logic [143:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [22:0]  cfg_wdata
);

  localparam int unsigned CntW = $clog2(MAX_NEIGHBORS + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_TEST  = 12'b000000000010,
    S_SQRT  = 12'b000000000100,
    S_DIVX  = 12'b000000001000,
    S_DIVY  = 12'b000000010000,
    S_ACC   = 12'b000000100000,
    S_FIN   = 12'b000001000000,
    S_MEAN  = 12'b000010000000,
    S_USHF  = 12'b000100000000,
    S_USQ   = 12'b001000000000,
    S_UDIV  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [22:0] rad_r [3];
  logic signed [23:0] fpx_r, fpy_r, fvx_r, fvy_r, npx_r, npy_r, nvx_r, nvy_r;
  logic self_r, last_r;
  logic signed [35:0] asx_r, asy_r;
  logic signed [33:0] psx_r, psy_r, vsx_r, vsy_r;
  logic [CntW-1:0] ccnt_r, acnt_r;
  logic signed [24:0] ax_r, ay_r;
  logic [63:0] d2_r, dist_r, qx_r;
  logic [1:0]  vec_r;     // 0 separation, 1 cohesion, 2 alignment
  logic [1:0]  step_r;    // sub-step within mean / unit vector
  logic signed [36:0] vx_r, vy_r;
  logic [36:0] mx_r, my_r;
  logic [63:0] nrm_r;
  logic signed [24:0] ux_r, uy_r;
  logic [143:0] odata_r;
  logic out_v_r;

  bsa_pkg::iu_ctl_t ctl;
  bsa_pkg::iu_sts_t sts;
  logic [63:0] opa, opb, ures;

  bsa_iter_unit u_iu (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .opa(opa), .opb(opb), .sts(sts), .res(ures)
  );

  function automatic logic [59:0] sq30(input logic [29:0] v);
    sq30 = v * v;
  endfunction

  function automatic logic [23:0] sat24(input logic signed [37:0] v);
    if (v > 38'sd8388607) sat24 = 24'h7FFFFF;
    else if (v < -38'sd8388608) sat24 = 24'h800000;
    else sat24 = v[23:0];
  endfunction

  function automatic logic signed [35:0] satadd36(input logic signed [35:0] a,
                                                   input logic signed [36:0] b);
    logic signed [37:0] s;
    s = 38'(a) + 38'(b);
    if (s > 38'sd34359738367) satadd36 = 36'sh7FFFFFFFF;
    else if (s < -38'sd34359738368) satadd36 = 36'sh800000000;
    else satadd36 = s[35:0];
  endfunction

  function automatic logic signed [33:0] satadd34(input logic signed [33:0] a,
                                                   input logic signed [23:0] b);
    logic signed [34:0] s;
    s = 35'(a) + 35'(b);
    if (s > 35'sd8589934591) satadd34 = 34'sh1FFFFFFFF;
    else if (s < -35'sd8589934592) satadd34 = 34'sh200000000;
    else satadd34 = s[33:0];
  endfunction

  logic [24:0] amx, amy;
  logic signed [36:0] mean_sel_x, mean_sel_y;
  logic [36:0] msx_mag, msy_mag;
  logic signed [36:0] qy_s, fin_x, fin_y;
  assign amx = ax_r[24] ? 25'(-ax_r) : 25'(ax_r);
  assign amy = ay_r[24] ? 25'(-ay_r) : 25'(ay_r);

  assign in_tready = (state_r == S_IDLE);

  // multiplexed square of the offsets and radius, one multiply per cycle
  logic [1:0] test_k_r;
  logic sep_hit_r, coh_hit_r, ali_hit_r;

  always_comb begin
    state_nxt = state_r;
    ctl.start = 1'b0;
    ctl.op    = bsa_pkg::OP_SQRT;
    opa       = '0;
    opb       = '0;
    unique case (state_r)
      S_IDLE: if (in_tvalid && in_tready) state_nxt = S_TEST;
      S_TEST: begin
        if (test_k_r == 2'd3) begin
          if (self_r) state_nxt = last_r ? S_FIN : S_IDLE;
          else if (sep_hit_r && d2_r != 64'd0) begin
            state_nxt = S_SQRT; ctl.start = 1'b1; opa = d2_r;
          end else state_nxt = S_ACC;
        end
      end
      S_SQRT: if (sts.done) begin
        state_nxt = S_DIVX; ctl.start = 1'b1; ctl.op = bsa_pkg::OP_DIV;
        opa = {27'd0, amx, 12'd0}; opb = ures;
      end
      S_DIVX: if (sts.done) begin
        state_nxt = S_DIVY; ctl.start = 1'b1; ctl.op = bsa_pkg::OP_DIV;
        opa = {27'd0, amy, 12'd0}; opb = dist_r;
      end
      S_DIVY: if (sts.done) state_nxt = S_ACC;
      S_ACC:  state_nxt = last_r ? S_FIN : S_IDLE;
      S_FIN:  if (!out_v_r) state_nxt = S_MEAN;
      S_MEAN: begin
        if (vec_r == 2'd0) state_nxt = S_USHF;
        else if (step_r == 2'd0) begin
          if ((vec_r == 2'd1 ? ccnt_r : acnt_r) == '0) state_nxt = S_USHF;
          else begin
            ctl.start = 1'b1; ctl.op = bsa_pkg::OP_DIV;
            opa = {27'd0, msx_mag}; opb = 64'(vec_r == 2'd1 ? ccnt_r : acnt_r);
          end
        end else if (sts.done) begin
          if (step_r == 2'd1) begin
            ctl.start = 1'b1; ctl.op = bsa_pkg::OP_DIV;
            opa = {27'd0, my_r}; opb = 64'(vec_r == 2'd1 ? ccnt_r : acnt_r);
          end else state_nxt = S_USHF;
        end
      end
      S_USHF: if (mx_r[36:30] == '0 && my_r[36:30] == '0) begin
        state_nxt = S_USQ; ctl.start = 1'b1;
        opa = 64'(sq30(mx_r[29:0])) + 64'(sq30(my_r[29:0]));
      end
      S_USQ: if (sts.done) begin
        if (ures == 64'd0) state_nxt = S_OUT;
        else begin
          state_nxt = S_UDIV; ctl.start = 1'b1; ctl.op = bsa_pkg::OP_DIV;
          opa = {22'd0, mx_r[29:0], 12'd0}; opb = ures;
        end
      end
      S_UDIV: if (sts.done) begin
        if (step_r == 2'd0) begin
          ctl.start = 1'b1; ctl.op = bsa_pkg::OP_DIV;
          opa = {22'd0, my_r[29:0], 12'd0}; opb = nrm_r;
        end else state_nxt = S_OUT;
      end
      S_OUT: state_nxt = (vec_r == 2'd2) ? S_IDLE : S_MEAN;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [63:0] d2_mul;
  always_comb begin
    case (test_k_r)
      2'd0: d2_mul = 64'(amx) * 64'(amx);
      2'd1: d2_mul = 64'(amy) * 64'(amy);
      default: d2_mul = 64'(rad_r[test_k_r - 2'd2]) * 64'(rad_r[test_k_r - 2'd2]);
    endcase
  end

  logic signed [24:0] ox, oy;
  logic [23:0] rx, ry;

  always_comb begin
    ox = ux_r;
    oy = uy_r;
    rx = '0;
    ry = '0;
    if (ux_r != '0 || uy_r != '0) begin
      if (vec_r == 2'd0) begin
        rx = sat24(38'(ux_r)); ry = sat24(38'(uy_r));
      end else begin
        rx = sat24(38'(ox) - 38'(fvx_r)); ry = sat24(38'(oy) - 38'(fvy_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rad_r[0] <= 23'd40960;
      rad_r[1] <= 23'd204800;
      rad_r[2] <= 23'd204800;
      asx_r <= '0; asy_r <= '0; psx_r <= '0; psy_r <= '0;
      vsx_r <= '0; vsy_r <= '0; ccnt_r <= '0; acnt_r <= '0;
      out_v_r <= 1'b0;
      test_k_r <= '0;
      vec_r <= '0; step_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          bsa_pkg::REG_SEP: rad_r[0] <= cfg_wdata;
          bsa_pkg::REG_COH: rad_r[1] <= cfg_wdata;
          bsa_pkg::REG_ALI: rad_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          {nvy_r, nvx_r, npy_r, npx_r, fvy_r, fvx_r, fpy_r, fpx_r} <= in_tdata;
          self_r <= in_tuser; last_r <= in_tlast;
          ax_r <= 25'(signed'(in_tdata[23:0])) - 25'(signed'(in_tdata[119:96]));
          ay_r <= 25'(signed'(in_tdata[47:24])) - 25'(signed'(in_tdata[143:120]));
          test_k_r <= '0;
        end
        S_TEST: begin
          test_k_r <= test_k_r + 2'd1;
          case (test_k_r)
            2'd0: d2_r <= d2_mul;
            2'd1: begin
              d2_r <= d2_r + d2_mul;
              sep_hit_r <= 1'b0;
            end
            default: ;
          endcase
        end
        S_SQRT: if (sts.done) dist_r <= ures;
        S_DIVX: if (sts.done) qx_r <= ures;
        S_DIVY: if (sts.done) begin
          asx_r <= satadd36(asx_r, ax_r[24] ? -37'(qx_r[35:0]) : 37'(qx_r[35:0]));
          asy_r <= satadd36(asy_r, ay_r[24] ? -37'(ures[35:0]) : 37'(ures[35:0]));
        end
        S_ACC: begin
          if (coh_hit_r && ccnt_r < CntW'(MAX_NEIGHBORS)) begin
            psx_r <= satadd34(psx_r, npx_r); psy_r <= satadd34(psy_r, npy_r);
            ccnt_r <= ccnt_r + 1'b1;
          end
          if (ali_hit_r && acnt_r < CntW'(MAX_NEIGHBORS)) begin
            vsx_r <= satadd34(vsx_r, nvx_r); vsy_r <= satadd34(vsy_r, nvy_r);
            acnt_r <= acnt_r + 1'b1;
          end
        end
        S_FIN: begin
          vec_r <= 2'd0; step_r <= 2'd0;
          vx_r <= 37'(asx_r); vy_r <= 37'(asy_r);
          mx_r <= asx_r[35] ? 37'(-37'(asx_r)) : 37'(asx_r);
          my_r <= asy_r[35] ? 37'(-37'(asy_r)) : 37'(asy_r);
          ux_r <= '0; uy_r <= '0;
        end
        S_MEAN: begin
          if (vec_r != 2'd0) begin
            if (step_r == 2'd0) begin
              ux_r <= '0; uy_r <= '0;
              vx_r <= mean_sel_x; vy_r <= mean_sel_y;
              if ((vec_r == 2'd1 ? ccnt_r : acnt_r) == '0) begin
                mx_r <= '0; my_r <= '0;
              end else begin
                mx_r <= msx_mag; my_r <= msy_mag;
                step_r <= 2'd1;
              end
            end else if (sts.done) begin
              if (step_r == 2'd1) begin
                vx_r <= vx_r[36] ? -37'(ures[36:0]) : 37'(ures[36:0]);
                step_r <= 2'd2;
              end else begin
                vx_r <= fin_x; vy_r <= fin_y;
                mx_r <= fin_x[36] ? 37'(-fin_x) : 37'(fin_x);
                my_r <= fin_y[36] ? 37'(-fin_y) : 37'(fin_y);
                step_r <= 2'd0;
              end
            end
          end
        end
        S_USHF: begin
          step_r <= 2'd0;
          if (mx_r[36:30] != '0 || my_r[36:30] != '0) begin
            mx_r <= mx_r >> 1; my_r <= my_r >> 1;
          end
        end
        S_USQ: if (sts.done) nrm_r <= ures;
        S_UDIV: if (sts.done) begin
          if (step_r == 2'd0) begin
            ux_r <= vx_r[36] ? -25'(ures[24:0]) : 25'(ures[24:0]);
            step_r <= 2'd1;
          end else
            uy_r <= vy_r[36] ? -25'(ures[24:0]) : 25'(ures[24:0]);
        end
        S_OUT: begin
          case (vec_r)
            2'd0: odata_r[47:0] <= {ry, rx};
            2'd1: odata_r[95:48] <= {ry, rx};
            default: begin
              odata_r[143:96] <= {ry, rx};
              out_v_r <= 1'b1;
              asx_r <= '0; asy_r <= '0; psx_r <= '0; psy_r <= '0;
              vsx_r <= '0; vsy_r <= '0; ccnt_r <= '0; acnt_r <= '0;
            end
          endcase
          vec_r <= vec_r + 2'd1;
          step_r <= 2'd0;
          ux_r <= '0; uy_r <= '0;
        end
        default: ;
      endcase
      if (state_r == S_TEST && test_k_r >= 2'd2) begin
        if (test_k_r == 2'd2) sep_hit_r <= d2_r <= d2_mul;
      end
    end
  end

  // radius hits: test_k 2 sep, then coh / ali compared in the final step
  logic [63:0] rc2, ra2;
  assign rc2 = 64'(rad_r[1]) * 64'(rad_r[1]);
  assign ra2 = 64'(rad_r[2]) * 64'(rad_r[2]);
  always_ff @(posedge clk) begin
    if (state_r == S_TEST && test_k_r == 2'd3) begin
      coh_hit_r <= d2_r <= rc2;
      ali_hit_r <= d2_r <= ra2;
    end
  end

  assign mean_sel_x = (vec_r == 2'd1) ? 37'(psx_r) : 37'(vsx_r);
  assign mean_sel_y = (vec_r == 2'd1) ? 37'(psy_r) : 37'(vsy_r);
  assign msx_mag = mean_sel_x[36] ? 37'(-mean_sel_x) : 37'(mean_sel_x);
  assign msy_mag = mean_sel_y[36] ? 37'(-mean_sel_y) : 37'(mean_sel_y);

  // mean y from the divider, then cohesion steers relative to the focal position
  assign qy_s  = vy_r[36] ? -37'(ures[36:0]) : 37'(ures[36:0]);
  assign fin_x = (vec_r == 2'd1) ? vx_r - 37'(fpx_r) : vx_r;
  assign fin_y = (vec_r == 2'd1) ? qy_s - 37'(fpy_r) : qy_s;

  assign out_tvalid = out_v_r;
  assign out_tdata  = odata_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("input taken while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ccnt_r <= CntW'(MAX_NEIGHBORS)) && (acnt_r <= CntW'(MAX_NEIGHBORS)))
    else $error("count overrun");

endmodule
